>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence at the same clock edge.
`define PGOL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgol: same-cycle check failed");

// Checks that a condition implies a consequence at the next clock edge.
`define PGOL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pgol: next-cycle check failed");

`endif

>>> rtl/pgol_pkg.sv
`timescale 1ns / 1ps

package pgol_pkg;

   // Field widths.
   localparam int FREQ_W  = 16;
   localparam int DUTY_W  = 8;
   localparam int STEP_W  = 8;
   localparam int PRE_W   = 10;
   localparam int TIMER_W = 16;

   // Default parameter values.
   localparam int STEPS_DEF            = 100;
   localparam int MAX_ON_TENTHS_MS_DEF = 50;
   localparam int CLOCK_HZ_DEF         = 16000000;

   // Largest compare value the timer accepts.
   localparam logic [TIMER_W-1:0] CMP_LIMIT = 16'hFFFE;

   // Tenths of a millisecond per second, and the width of that scale times the largest duty.
   localparam int ON_SCALE = 10000;
   localparam int SCALE_W  = $clog2(ON_SCALE * 255 + 1);

   // Prescaler selection codes.
   typedef enum logic [2:0] {
      PRE_DIV1,
      PRE_DIV8,
      PRE_DIV64,
      PRE_DIV256,
      PRE_DIV1024
   } prescale_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic mul_en;
      logic div_start;
      logic on_load;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic stop;
      logic over;
      logic div_done;
   } status_type;

   // Division ratio of a prescaler code; codes without a meaning divide by one.
   function automatic logic [PRE_W:0] prescale_div(input prescale_type code);
      logic [PRE_W:0] ratio;
      case (code)
         PRE_DIV1:    ratio = (PRE_W+1)'(1);
         PRE_DIV8:    ratio = (PRE_W+1)'(8);
         PRE_DIV64:   ratio = (PRE_W+1)'(64);
         PRE_DIV256:  ratio = (PRE_W+1)'(256);
         PRE_DIV1024: ratio = (PRE_W+1)'(1024);
         default:     ratio = (PRE_W+1)'(1);
      endcase
      return ratio;
   endfunction

endpackage

>>> rtl/pgol_divider.sv
`timescale 1ns / 1ps

module pgol_divider #(
   parameter int DIV_W = 32,
   parameter int DVS_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_sub;
   logic             fits;

   // One restoring step per cycle: dividend bits shift out at the top,
   // quotient bits shift in at the bottom.
   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_W-1]};
      fits      = trial >= {1'b0, dvs_ff};
      trial_sub = trial - {1'b0, dvs_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/pgol_ctrl.sv
`timescale 1ns / 1ps

module pgol_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 restart_beat,
   input  pgol_pkg::status_type status,
   output pgol_pkg::cmd_type    cmd,
   output logic                 busy
);

   import pgol_pkg::*;

   typedef enum logic [2:0] {
      S_RUN,
      S_MUL,
      S_CHECK,
      S_CR_DIV,
      S_FINISH
   } state_type;

   state_type state_ff;
   cmd_type   cmd_ff;
   logic      busy_ff;

   // Derivation sequence after a restart that starts the timer. Commands are
   // one-cycle pulses.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         cmd_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         cmd_ff <= '0;
         case (state_ff)
            S_RUN: begin
               if (restart_beat && !status.stop) begin
                  state_ff      <= S_MUL;
                  cmd_ff.mul_en <= 1'b1;
                  busy_ff       <= 1'b1;
               end
            end
            S_MUL: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               cmd_ff.div_start <= 1'b1;
               cmd_ff.on_load   <= status.over;
               state_ff         <= S_CR_DIV;
            end
            S_CR_DIV: begin
               if (status.div_done) begin
                  cmd_ff.finish <= 1'b1;
                  state_ff      <= S_FINISH;
               end
            end
            S_FINISH: begin
               busy_ff  <= 1'b0;
               state_ff <= S_RUN;
            end
            default: begin
               busy_ff  <= 1'b0;
               state_ff <= S_RUN;
            end
         endcase
      end
   end

   assign cmd  = cmd_ff;
   assign busy = busy_ff;

endmodule

>>> rtl/pgol_datapath.sv
`timescale 1ns / 1ps

module pgol_datapath #(
   parameter int STEPS            = pgol_pkg::STEPS_DEF,
   parameter int MAX_ON_TENTHS_MS = pgol_pkg::MAX_ON_TENTHS_MS_DEF,
   parameter int CLOCK_HZ         = pgol_pkg::CLOCK_HZ_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_beat,
   input  logic                        item_restart,
   input  logic [pgol_pkg::FREQ_W-1:0] cfg_freq,
   input  logic [pgol_pkg::DUTY_W-1:0] cfg_duty,
   input  pgol_pkg::cmd_type           cmd,
   output pgol_pkg::status_type        status,
   output logic                        pin_next,
   output logic                        event_next,
   output logic [pgol_pkg::STEP_W-1:0] step_next
);

   import pgol_pkg::*;

   // Over-limit test: floor(ON_SCALE*on/(STEPS*f)) > MAX is ON_SCALE*on >= (MAX+1)*STEPS*f.
   localparam int K_LIM  = (MAX_ON_TENTHS_MS + 1) * STEPS;
   localparam int K_NEW  = MAX_ON_TENTHS_MS * STEPS;
   localparam int LIM_W  = $clog2(K_LIM + 1);
   localparam int PROD_W = LIM_W + FREQ_W;
   localparam int CR_NUM = CLOCK_HZ / STEPS;
   localparam int CR_W   = $clog2(CR_NUM + 1);
   localparam int DIV_W  = (CR_W > TIMER_W) ? CR_W : TIMER_W;
   localparam int CMP_W  = (PROD_W > SCALE_W) ? PROD_W : SCALE_W;
   localparam logic [DIV_W-1:0] LIMIT_X = DIV_W'(CMP_LIMIT);

   // Reciprocal of ON_SCALE, exact for every dividend below 2**SCALE_W.
   localparam int     REC_SH    = SCALE_W + $clog2(ON_SCALE);
   localparam int     REC_W     = SCALE_W + 1;
   localparam int     ON_PROD_W = SCALE_W + REC_W;
   localparam longint REC_MUL   = ((longint'(1) << REC_SH) + longint'(ON_SCALE) - 1)
                                  / longint'(ON_SCALE);

   // Working copies of the settings during derivation.
   logic [FREQ_W-1:0]  f_ff, f_in;
   logic [DUTY_W-1:0]  on_ff, on_in;
   logic [PROD_W-1:0]  lim_prod_ff, lim_prod_in;
   logic [PROD_W-1:0]  new_prod_ff, new_prod_in;
   logic [SCALE_W-1:0] scaled_on_ff, scaled_on_in;

   // Derived settings.
   logic [TIMER_W-1:0] cmp_ff, cmp_in;
   prescale_type       code_ff, code_in;
   logic [DUTY_W-1:0]  on_steps_ff, on_steps_in;
   logic               running_ff, running_in;

   // Counters and pin.
   logic [PRE_W-1:0]   ps_ff, ps_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               pin_ff, pin_in;

   logic                 step_adv;
   logic                 tick;
   logic [PRE_W:0]       ps_next;
   logic [DIV_W-1:0]     div_dividend;
   logic [FREQ_W-1:0]    div_divisor;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quotient;
   logic [DIV_W-1:0]     cr_s3, cr_s6, cr_s8, cr_s10;
   logic [TIMER_W-1:0]   crv;
   prescale_type         crv_code;
   logic [ON_PROD_W-1:0] on_prod;
   logic [DUTY_W-1:0]    on_cut;

   // Iterative divider for the compare value.
   assign div_dividend = DIV_W'(CR_NUM);
   assign div_divisor  = f_ff;

   pgol_divider #(
      .DIV_W (DIV_W),
      .DVS_W (FREQ_W)
   ) u_pgol_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Limited on steps: the product is below ON_SCALE*on whenever the limit applies,
   // so it fits SCALE_W bits and the reciprocal multiply gives the exact floor.
   always_comb begin
      on_prod = ON_PROD_W'(SCALE_W'(new_prod_ff)) * ON_PROD_W'(REC_MUL);
      on_cut  = on_prod[REC_SH +: DUTY_W];
   end

   // Status toward the controller.
   always_comb begin
      status.stop     = (cfg_freq == '0) || (cfg_duty == '0);
      status.over     = CMP_W'(scaled_on_ff) >= CMP_W'(lim_prod_ff);
      status.div_done = div_done;
   end

   // Smallest prescaler that keeps the compare value in range, else saturate.
   always_comb begin
      cr_s3  = div_quotient >> 3;
      cr_s6  = div_quotient >> 6;
      cr_s8  = div_quotient >> 8;
      cr_s10 = div_quotient >> 10;
      if (div_quotient <= LIMIT_X) begin
         crv_code = PRE_DIV1;
         crv      = div_quotient[TIMER_W-1:0];
      end else if (cr_s3 <= LIMIT_X) begin
         crv_code = PRE_DIV8;
         crv      = cr_s3[TIMER_W-1:0];
      end else if (cr_s6 <= LIMIT_X) begin
         crv_code = PRE_DIV64;
         crv      = cr_s6[TIMER_W-1:0];
      end else if (cr_s8 <= LIMIT_X) begin
         crv_code = PRE_DIV256;
         crv      = cr_s8[TIMER_W-1:0];
      end else if (cr_s10 <= LIMIT_X) begin
         crv_code = PRE_DIV1024;
         crv      = cr_s10[TIMER_W-1:0];
      end else begin
         crv_code = PRE_DIV1024;
         crv      = CMP_LIMIT;
      end
   end

   // Prescaler, timer and step counter for a normal tick.
   always_comb begin
      ps_next  = {1'b0, ps_ff} + (PRE_W+1)'(1);
      tick     = ps_next >= prescale_div(code_ff);
      step_adv = tick && (timer_ff == cmp_ff);
   end

   // Next state of everything.
   always_comb begin
      f_in         = f_ff;
      on_in        = on_ff;
      lim_prod_in  = lim_prod_ff;
      new_prod_in  = new_prod_ff;
      scaled_on_in = scaled_on_ff;
      cmp_in       = cmp_ff;
      code_in      = code_ff;
      on_steps_in  = on_steps_ff;
      running_in   = running_ff;
      ps_in        = ps_ff;
      timer_in     = timer_ff;
      step_in      = step_ff;
      pin_in       = pin_ff;
      event_next   = 1'b0;

      if (item_beat && item_restart) begin
         ps_in    = '0;
         timer_in = '0;
         step_in  = '0;
         if (status.stop) begin
            running_in  = 1'b0;
            pin_in      = 1'b0;
            cmp_in      = '0;
            code_in     = PRE_DIV1;
            on_steps_in = '0;
         end else begin
            f_in  = cfg_freq;
            on_in = (cfg_duty > DUTY_W'(STEPS)) ? DUTY_W'(STEPS) : cfg_duty;
         end
      end else if (item_beat && running_ff) begin
         ps_in = tick ? '0 : ps_next[PRE_W-1:0];
         if (tick) begin
            timer_in = step_adv ? '0 : timer_ff + TIMER_W'(1);
         end
         if (step_adv) begin
            event_next = 1'b1;
            if (step_ff == '0) begin
               if (on_steps_ff != '0) begin
                  pin_in = 1'b1;
               end
            end else if (step_ff == on_steps_ff) begin
               pin_in = 1'b0;
            end
            step_in = (step_ff == STEP_W'(STEPS - 1)) ? '0 : step_ff + STEP_W'(1);
         end
      end

      // Derivation steps driven by the controller.
      if (cmd.mul_en) begin
         lim_prod_in  = PROD_W'(K_LIM) * PROD_W'(f_ff);
         new_prod_in  = PROD_W'(K_NEW) * PROD_W'(f_ff);
         scaled_on_in = SCALE_W'(ON_SCALE) * SCALE_W'(on_ff);
      end
      if (cmd.on_load) begin
         on_in = on_cut;
      end
      if (cmd.finish) begin
         cmp_in      = crv;
         code_in     = crv_code;
         on_steps_in = on_ff;
         running_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      f_ff         <= f_in;
      on_ff        <= on_in;
      lim_prod_ff  <= lim_prod_in;
      new_prod_ff  <= new_prod_in;
      scaled_on_ff <= scaled_on_in;
      if (reset) begin
         cmp_ff      <= '0;
         code_ff     <= PRE_DIV1;
         on_steps_ff <= '0;
         running_ff  <= 1'b0;
         ps_ff       <= '0;
         timer_ff    <= '0;
         step_ff     <= '0;
         pin_ff      <= 1'b0;
      end else begin
         cmp_ff      <= cmp_in;
         code_ff     <= code_in;
         on_steps_ff <= on_steps_in;
         running_ff  <= running_in;
         ps_ff       <= ps_in;
         timer_ff    <= timer_in;
         step_ff     <= step_in;
         pin_ff      <= pin_in;
      end
   end

   assign pin_next  = pin_in;
   assign step_next = step_in;

endmodule

>>> rtl/pulse_generator_on_time_limit_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Beat contents
// req       in         req_valid/req_stall  req_restart
// rsp       out        rsp_valid/rsp_stall  rsp_pin, rsp_step_event, rsp_step_index
// csr       in/out     psel/penable/pready  freq_hz at 0x0, duty_steps at 0x4
//
// A normal tick's result is registered and appears in the cycle after acceptance.
// A restart that starts the timer stalls req while the controller derives the
// settings; the divider for CLOCK_HZ/STEPS/freq finds one quotient bit per cycle.
// A restart with zero frequency or duty stops the timer without a derivation or stall.
// Reset is synchronous and clears the counters, settings and rsp_valid to zero.
// A stalled result holds; a new beat is taken only when the result register is free.

module pulse_generator_on_time_limit_unit #(
   parameter int STEPS            = pgol_pkg::STEPS_DEF,
   parameter int MAX_ON_TENTHS_MS = pgol_pkg::MAX_ON_TENTHS_MS_DEF,
   parameter int CLOCK_HZ         = pgol_pkg::CLOCK_HZ_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_pin,
   output logic                        rsp_step_event,
   output logic [pgol_pkg::STEP_W-1:0] rsp_step_index,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   import pgol_pkg::*;

   localparam logic CSR_FREQ = 1'b0;
   localparam logic CSR_DUTY = 1'b1;

   logic [FREQ_W-1:0] freq_ff;
   logic [DUTY_W-1:0] duty_ff;
   logic              rsp_valid_ff;
   logic              rsp_pin_ff;
   logic              rsp_event_ff;
   logic [STEP_W-1:0] rsp_step_ff;
   logic              busy;
   logic              item_beat;
   logic              csr_write;
   cmd_type           cmd;
   status_type        status;
   logic              pin_next;
   logic              event_next;
   logic [STEP_W-1:0] step_next;

   // Handshake: hold off while deriving or while a result waits.
   assign req_stall = busy || (rsp_valid_ff && rsp_stall);
   assign item_beat = req_valid && !req_stall;

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= '0;
         duty_ff <= '0;
      end else if (csr_write) begin
         if (paddr[2] == CSR_FREQ) begin
            freq_ff <= pwdata[FREQ_W-1:0];
         end
         if (paddr[2] == CSR_DUTY) begin
            duty_ff <= pwdata[DUTY_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == CSR_DUTY) ? 32'(duty_ff) : 32'(freq_ff);

   pgol_ctrl u_pgol_ctrl (
      .clock        (clock),
      .reset        (reset),
      .restart_beat (item_beat && req_restart),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy)
   );

   pgol_datapath #(
      .STEPS            (STEPS),
      .MAX_ON_TENTHS_MS (MAX_ON_TENTHS_MS),
      .CLOCK_HZ         (CLOCK_HZ)
   ) u_pgol_datapath (
      .clock        (clock),
      .reset        (reset),
      .item_beat    (item_beat),
      .item_restart (req_restart),
      .cfg_freq     (freq_ff),
      .cfg_duty     (duty_ff),
      .cmd          (cmd),
      .status       (status),
      .pin_next     (pin_next),
      .event_next   (event_next),
      .step_next    (step_next)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (item_beat) begin
         rsp_pin_ff   <= pin_next;
         rsp_event_ff <= event_next;
         rsp_step_ff  <= step_next;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin        = rsp_pin_ff;
   assign rsp_step_event = rsp_event_ff;
   assign rsp_step_index = rsp_step_ff;

endmodule

>>> rtl/pgol_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pgol_assertions #(
   parameter int STEPS = pgol_pkg::STEPS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_restart,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_pin,
   input logic                        rsp_step_event,
   input logic [pgol_pkg::STEP_W-1:0] rsp_step_index
);

   import pgol_pkg::*;

   // A stalled result stays put.
   `PGOL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pin) && $stable(rsp_step_event) && $stable(rsp_step_index))

   // Every accepted beat gives a result on the next cycle.
   `PGOL_ASSERT_NEXT(a_beat_result, clock, reset, req_valid && !req_stall, rsp_valid)

   // A restart result shows step zero and no step event.
   `PGOL_ASSERT_NEXT(a_restart_clear, clock, reset, req_valid && !req_stall && req_restart, (rsp_step_index == '0) && !rsp_step_event)

   // The step index stays within the period.
   `PGOL_ASSERT_NOW(a_step_range, clock, reset, rsp_valid, rsp_step_index < STEP_W'(STEPS))

endmodule

bind pulse_generator_on_time_limit_unit pgol_assertions #(
   .STEPS (STEPS)
) u_pgol_assertions (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_restart    (req_restart),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pin        (rsp_pin),
   .rsp_step_event (rsp_step_event),
   .rsp_step_index (rsp_step_index)
);

>>> dv/pgol_checker.sv
`timescale 1ns / 1ps

module pgol_checker #(
   parameter int         STEPS            = pgol_pkg::STEPS_DEF,
   parameter int         MAX_ON_TENTHS_MS = pgol_pkg::MAX_ON_TENTHS_MS_DEF,
   parameter int         CLOCK_HZ         = pgol_pkg::CLOCK_HZ_DEF,
   parameter logic [2:0] FREQ_ADDR        = 3'd0,
   parameter logic [2:0] DUTY_ADDR        = 3'd4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_restart,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_pin,
   input  logic                        rsp_step_event,
   input  logic [pgol_pkg::STEP_W-1:0] rsp_step_index,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   input  logic [31:0]                 prdata,
   input  logic                        pready,
   output int                          fail_count,
   output int                          waiting,
   output int                          result_count,
   output int                          event_count
);
   import pgol_pkg::*;

   // One result beat: pin level, step event and step index after a tick.
   typedef struct packed {
      logic              pin;
      logic              step_event;
      logic [STEP_W-1:0] step_index;
   } tick_result_t;

   tick_result_t expected_ticks[$];

   // Register copies, written over the configuration port.
   logic [FREQ_W-1:0] freq_reg;
   logic [DUTY_W-1:0] duty_reg;

   // Timer state as the block should hold it.
   logic [PRE_W-1:0]   pre_cnt;
   logic [TIMER_W-1:0] tmr_cnt;
   logic [STEP_W-1:0]  step_cnt;
   logic               pin_lvl;
   logic [TIMER_W-1:0] cmp_val;
   prescale_type       pre_code;
   logic [STEP_W-1:0]  on_cnt;
   logic               running;

   longint unsigned ratio_table [0:4];

   initial begin
      ratio_table[0] = 1;
      ratio_table[1] = 8;
      ratio_table[2] = 64;
      ratio_table[3] = 256;
      ratio_table[4] = 1024;
   end

   task automatic check_field(input string what, input longint unsigned exp_v,
                              input longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Works out on steps, prescaler and compare value from the registers.
   task automatic derive_timing();
      longint unsigned f;
      longint unsigned on;
      longint unsigned ratio;
      longint unsigned scaled;
      int              code;
      pre_cnt  = '0;
      tmr_cnt  = '0;
      step_cnt = '0;
      f  = freq_reg;
      on = duty_reg;
      if (f == 0 || on == 0) begin
         running  = 1'b0;
         pin_lvl  = 1'b0;
         cmp_val  = '0;
         pre_code = PRE_DIV1;
         on_cnt   = '0;
      end else begin
         if (on > STEPS) on = STEPS;
         // Cut the on steps back when the on time would exceed the limit.
         if (ON_SCALE * on / (STEPS * f) > MAX_ON_TENTHS_MS)
            on = MAX_ON_TENTHS_MS * STEPS * f / ON_SCALE;
         on_cnt = on[STEP_W-1:0];
         // Smallest prescaler that brings the compare value into range.
         ratio  = (CLOCK_HZ / STEPS) / f;
         scaled = ratio;
         code   = 0;
         while (scaled > CMP_LIMIT && code < 4) begin
            code++;
            scaled = ratio / ratio_table[code];
         end
         if (scaled > CMP_LIMIT) scaled = CMP_LIMIT;
         cmp_val  = scaled[TIMER_W-1:0];
         pre_code = prescale_type'(code);
         running  = 1'b1;
      end
   endtask

   // Advances the timer by one base tick, or restarts it.
   task automatic predict_tick(input logic restart, output tick_result_t r);
      logic hit;
      logic tick;
      hit  = 1'b0;
      tick = 1'b0;
      if (restart) begin
         derive_timing();
      end else if (running) begin
         if (longint'(pre_cnt) + 1 >= ratio_table[int'(pre_code)]) begin
            pre_cnt = '0;
            tick    = 1'b1;
         end else begin
            pre_cnt = pre_cnt + 1'b1;
         end
         if (tick) begin
            if (tmr_cnt == cmp_val) begin
               tmr_cnt = '0;
               hit     = 1'b1;
            end else begin
               tmr_cnt = tmr_cnt + 1'b1;
            end
         end
         // The pin rises at step zero and falls at the on-step count.
         if (hit) begin
            if (step_cnt == 0) begin
               if (on_cnt != 0) pin_lvl = 1'b1;
            end else if (step_cnt == on_cnt) begin
               pin_lvl = 1'b0;
            end
            step_cnt = STEP_W'((int'(step_cnt) + 1) % STEPS);
         end
      end
      r.pin        = pin_lvl;
      r.step_event = hit;
      r.step_index = step_cnt;
   endtask

   // Watches the register port and both channels at every rising edge.
   always @(posedge clock) begin
      tick_result_t want;
      tick_result_t got;
      if (reset) begin
         expected_ticks.delete();
         freq_reg     = '0;
         duty_reg     = '0;
         pre_cnt      = '0;
         tmr_cnt      = '0;
         step_cnt     = '0;
         pin_lvl      = 1'b0;
         cmp_val      = '0;
         pre_code     = PRE_DIV1;
         on_cnt       = '0;
         running      = 1'b0;
         fail_count   = 0;
         result_count = 0;
         event_count  = 0;
      end else begin
         // Register writes and read-backs.
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == FREQ_ADDR) freq_reg = pwdata[FREQ_W-1:0];
               else if (paddr == DUTY_ADDR) duty_reg = pwdata[DUTY_W-1:0];
            end else if (paddr == FREQ_ADDR) begin
               check_field("freq_hz read", {16'b0, freq_reg}, prdata);
            end else if (paddr == DUTY_ADDR) begin
               check_field("duty_steps read", {24'b0, duty_reg}, prdata);
            end
         end

         // Each accepted tick beat yields one expected result.
         if (req_valid && !req_stall) begin
            predict_tick(req_restart, want);
            expected_ticks.push_back(want);
         end

         // Compare each result beat with the oldest expectation.
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pin, rsp_step_event, rsp_step_index};
            if (expected_ticks.size() == 0) begin
               $display("%0t ns: result beat with nothing expected, actual %0h", $time, got);
               fail_count++;
            end else begin
               want = expected_ticks.pop_front();
               check_field("pin", want.pin, got.pin);
               check_field("step_event", want.step_event, got.step_event);
               check_field("step_index", want.step_index, got.step_index);
               result_count++;
               if (want.step_event) event_count++;
            end
         end
      end
      waiting = expected_ticks.size();
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pgol_pkg::*;

   localparam logic [2:0] FREQ_ADDR   = 3'd0;
   localparam logic [2:0] DUTY_ADDR   = 3'd4;
   localparam int         ITEM_TARGET = 1750;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   logic              req_restart = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   logic              rsp_pin;
   logic              rsp_step_event;
   logic [STEP_W-1:0] rsp_step_index;
   logic              psel        = 1'b0;
   logic              penable     = 1'b0;
   logic              pwrite      = 1'b0;
   logic [2:0]        paddr       = '0;
   logic [31:0]       pwdata      = '0;
   logic [31:0]       prdata;
   logic              pready;

   int fail_count;
   int waiting;
   int result_count;
   int event_count;
   int beats_sent  = 0;
   int settings    = 0;
   int idle_level  = 0;
   int stall_left  = 0;

   always #2 clock = ~clock;

   pulse_generator_on_time_limit_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pin        (rsp_pin),
      .rsp_step_event (rsp_step_event),
      .rsp_step_index (rsp_step_index),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   pgol_checker #(
      .FREQ_ADDR (FREQ_ADDR),
      .DUTY_ADDR (DUTY_ADDR)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pin        (rsp_pin),
      .rsp_step_event (rsp_step_event),
      .rsp_step_index (rsp_step_index),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .fail_count     (fail_count),
      .waiting        (waiting),
      .result_count   (result_count),
      .event_count    (event_count)
   );

   // Result stall comes in bursts of random length; none at idle level zero.
   always @(posedge clock) begin
      if (reset || idle_level == 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < idle_level * 8) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offers one tick beat and holds it until accepted, then maybe idles a burst.
   task automatic send_beat(input logic restart);
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      beats_sent++;
      if (idle_level != 0 && $urandom_range(0, 99) < idle_level * 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // One register access: setup cycle, then access cycle until pready.
   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Holds off new beats until every expected result has come back and the
   // block has finished any derivation.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (waiting != 0 || req_stall) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes a new setting while idle, reads it back and optionally restarts.
   task automatic apply_setting(input logic [15:0] f, input logic [7:0] d,
                                input bit write_freq, input bit write_duty, input bit restart);
      drain_results();
      if (write_freq) csr_access(1'b1, FREQ_ADDR, {16'($urandom()), f});
      if (write_duty) csr_access(1'b1, DUTY_ADDR, {24'($urandom()), d});
      csr_access(1'b0, FREQ_ADDR, '0);
      csr_access(1'b0, DUTY_ADDR, '0);
      settings++;
      if (restart) send_beat(1'b1);
   endtask

   initial begin
      int          kind;
      int          ticks;
      int          limit;
      int          restart_pct;
      logic [15:0] f;
      logic [7:0]  d;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Ticks before any restart: the block is stopped.
      send_beat(1'b0);
      send_beat(1'b0);
      // Zero duty, then zero frequency: both stop with the pin low.
      apply_setting(16'hFFFF, 8'd0, 1, 1, 1);
      send_beat(1'b0);
      apply_setting(16'd0, 8'hFF, 1, 1, 1);
      send_beat(1'b0);
      // Top frequency with duty above the step count: clamped, pin stays high.
      apply_setting(16'hFFFF, 8'hFF, 1, 1, 1);
      repeat (8) send_beat(1'b0);
      // Restart while running keeps the pin level until the next match.
      send_beat(1'b1);
      repeat (2) send_beat(1'b0);
      // Lowest frequency: the on-time limit leaves no on steps, divide by 8.
      apply_setting(16'd1, 8'd1, 1, 1, 1);
      repeat (2) send_beat(1'b0);
      // New register values without restart are stored but have no effect.
      apply_setting(16'd40000, 8'd50, 1, 1, 0);
      repeat (3) send_beat(1'b0);

      // Random settings, each followed by a run of ticks with rare restarts.
      while (beats_sent < ITEM_TARGET) begin
         idle_level <= (beats_sent >= ITEM_TARGET - 200) ? 0 : $urandom_range(0, 3);
         kind = $urandom_range(0, 11);
         case (kind)
            0: begin
               f     = 16'($urandom_range(1, 199));
               d     = 8'($urandom_range(1, 255));
               ticks = $urandom_range(100, 900);
            end
            1: begin
               f     = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 65535));
               d     = (f == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
               ticks = $urandom_range(20, 60);
            end
            2: begin
               f     = 16'($urandom_range(0, 65535));
               d     = 8'($urandom_range(0, 255));
               ticks = $urandom_range(20, 200);
            end
            default: begin
               f     = 16'($urandom_range(16000, 65535));
               d     = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(101, 255))
                                                    : 8'($urandom_range(1, 100));
               ticks = $urandom_range(50, 300);
            end
         endcase
         restart_pct = $urandom_range(0, 3);
         apply_setting(f, d, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                       $urandom_range(0, 7) != 0);
         // Stop each run at the start of the quiet tail or at the item target.
         limit = ((beats_sent < ITEM_TARGET - 200) ? ITEM_TARGET - 200 : ITEM_TARGET)
                 - beats_sent;
         if (ticks > limit) ticks = limit;
         repeat (ticks) send_beat($urandom_range(0, 99) < restart_pct);
      end

      drain_results();
      repeat (70) @(posedge clock);
      @(negedge clock);
      $display("Run covered %0d tick beats over %0d register settings.", beats_sent, settings);
      $display("%0d result beats checked, %0d of them with a step event.",
               result_count, event_count);
      if (fail_count == 0 && waiting == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> pulse_generator_on_time_limit_unit.f
+incdir+rtl
rtl/pgol_pkg.sv
rtl/pgol_divider.sv
rtl/pgol_ctrl.sv
rtl/pgol_datapath.sv
rtl/pulse_generator_on_time_limit_unit.sv
rtl/pgol_checker.sv
dv/pgol_checker.sv
dv/tb_top.sv
